[sv/gbz_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_pkg
// Shared constants, types and helpers of the 7x7 zero-border Gaussian blur.
// ----------------------------------------------------------------------------
package gbz_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int RING_ROWS = 16;
  localparam int RING_BITS = 4;
  localparam int KHALF     = 3;
  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int HW        = 12;
  localparam int NW        = WW + HW;
  localparam int ADDR_W    = $clog2(RING_ROWS * MAX_WIDTH);
  localparam int ACC_W     = 30;
  localparam int PROD_W    = ACC_W + 24;
  localparam int CFG_IW    = 3;

  localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] REG_W0     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_W1     = 3'd3;
  localparam logic [CFG_IW-1:0] REG_W2     = 3'd4;
  localparam logic [CFG_IW-1:0] REG_W3     = 3'd5;
  localparam logic [CFG_IW-1:0] REG_NORM   = 3'd6;

  typedef struct packed {
    logic [WW-1:0] width;
    logic [HW-1:0] height;
    logic [7:0]    w0;
    logic [7:0]    w1;
    logic [7:0]    w2;
    logic [7:0]    w3;
    logic [23:0]   norm;
  } cfg_t;

  typedef struct packed {
    logic [HW-1:0] row;
    logic [CW-1:0] col;
    logic          last;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic q_full;
    logic q_empty;
    logic back_idle;
  } status_t;

  // 1-D weight for a tap step of 0..6 across the window
  function automatic logic [7:0] weight_sel(input cfg_t c, input logic [2:0] t);
    logic [7:0] w;
    case (t)
      3'd3:       w = c.w0;
      3'd2, 3'd4: w = c.w1;
      3'd1, 3'd5: w = c.w2;
      default:    w = c.w3;
    endcase
    return w;
  endfunction

endpackage

[sv/gbz_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_if
// Valid/ready channels of the blur: pixel input, result output, register write.
// ----------------------------------------------------------------------------
interface gbz_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel_in;
  modport source (output valid, req_type, pixel_in, input ready);
  modport sink   (input valid, req_type, pixel_in, output ready);
endinterface

interface gbz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       last_of_frame;
  modport source (output valid, pixel_out, last_of_frame, input ready);
  modport sink   (input valid, pixel_out, last_of_frame, output ready);
endinterface

interface gbz_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gbz_pkg::CFG_IW-1:0]     index;
  logic [31:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/gaussian_blur_7x7_zero_border.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_7x7_zero_border
// 7x7 separable Gaussian blur over a raster pixel stream, zero borders.
// ----------------------------------------------------------------------------
// A scheduled result passes the job queue, the tap walk, the pipeline drain, the
//   scaling and the output register before it is valid. Results come one job at
//   a time: the 49-tap walk runs through the single read port of the line store.
// Reset (synchronous, rst_n low): counters, queue and control clear, registers
//   take their defaults; the line store is not cleared, since every tap read
//   was written earlier in the same frame.
module gaussian_blur_7x7_zero_border (
  input  logic       clk,
  input  logic       rst_n,
  gbz_in_if.sink     in_if,
  gbz_out_if.source  out_if,
  gbz_cfg_if.sink    cfg_if
);

  gbz_pkg::cfg_t    cfg;
  gbz_pkg::mem_wr_t wr;
  gbz_pkg::status_t stat;
  gbz_pkg::job_t    push_job, q_head;
  logic             push, pop, q_full, q_empty, back_idle;
  logic [gbz_pkg::ADDR_W-1:0] raddr;
  logic [7:0]       rdata;

  assign stat = '{q_full: q_full, q_empty: q_empty, back_idle: back_idle};

  gbz_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .cfg_if   (cfg_if),
    .stat     (stat),
    .cfg      (cfg),
    .wr       (wr),
    .push     (push),
    .push_job (push_job)
  );

  gbz_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  gbz_ram #(
    .WIDTH (8),
    .DEPTH (gbz_pkg::RING_ROWS * gbz_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  gbz_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .pop     (pop),
    .idle    (back_idle),
    .raddr   (raddr),
    .rdata   (rdata),
    .out_if  (out_if)
  );

endmodule

[sv/gbz_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/gbz_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module gbz_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gbz_pkg::job_t push_job,
  input  logic          pop,
  output gbz_pkg::job_t head,
  output logic          full,
  output logic          empty
);

  gbz_pkg::job_t ent_r [2];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          rd_r, wr_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_job;
    end
  end

endmodule

[sv/gbz_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_front
// Register bank, raster counters, line store writes and output scheduling.
// ----------------------------------------------------------------------------
module gbz_front (
  input  logic              clk,
  input  logic              rst_n,
  gbz_in_if.sink            in_if,
  gbz_cfg_if.sink           cfg_if,
  input  gbz_pkg::status_t  stat,
  output gbz_pkg::cfg_t     cfg,
  output gbz_pkg::mem_wr_t  wr,
  output logic              push,
  output gbz_pkg::job_t     push_job
);

  logic [10:0] width_raw_r;
  logic [11:0] height_raw_r;
  logic [7:0]  w0_r, w1_r, w2_r, w3_r;
  logic [23:0] norm_r;

  logic [gbz_pkg::WW-1:0] w_eff;
  logic [gbz_pkg::HW-1:0] h_eff;
  logic [gbz_pkg::NW-1:0] n_eff, lag_eff;

  logic [gbz_pkg::CW-1:0] col_r, col_nxt, ocol_r, ocol_nxt;
  logic [gbz_pkg::HW-1:0] row_r, row_nxt, orow_r, orow_nxt;
  logic [gbz_pkg::NW-1:0] rcv_r, rcv_nxt, oc_r, oc_nxt;
  logic [gbz_pkg::NW-1:0] rcv_inc;

  logic accept, cfg_wr, geom_wr, drain, is_pix, emit, last;

  always_comb begin
    if (width_raw_r == 11'd0) begin
      w_eff = gbz_pkg::WW'(1);
    end else if (32'(width_raw_r) > gbz_pkg::MAX_WIDTH) begin
      w_eff = gbz_pkg::WW'(gbz_pkg::MAX_WIDTH);
    end else begin
      w_eff = gbz_pkg::WW'(width_raw_r);
    end
    h_eff = (height_raw_r == 12'd0) ? 12'd1 : height_raw_r;
  end

  // frame size and output lag follow the geometry registers at once
  assign n_eff   = gbz_pkg::NW'(w_eff) * gbz_pkg::NW'(h_eff);
  assign lag_eff = gbz_pkg::NW'(w_eff) * gbz_pkg::NW'(3) + gbz_pkg::NW'(4);

  assign cfg = '{width: w_eff, height: h_eff, w0: w0_r, w1: w1_r, w2: w2_r, w3: w3_r,
                 norm: norm_r};

  // a new frame waits until the back no longer reads the ring
  assign in_if.ready  = !stat.q_full &&
                        !((rcv_r == '0) && !(stat.q_empty && stat.back_idle));
  assign cfg_if.ready = 1'b1;

  assign accept  = in_if.valid && in_if.ready;
  assign cfg_wr  = cfg_if.valid && cfg_if.ready;
  assign geom_wr = cfg_wr && ((cfg_if.index == gbz_pkg::REG_WIDTH) ||
                              (cfg_if.index == gbz_pkg::REG_HEIGHT));

  assign rcv_inc = rcv_r + 1'b1;
  assign drain   = (rcv_r >= n_eff);
  assign is_pix  = !drain && !in_if.req_type;
  assign emit    = accept && (drain || (is_pix && ((rcv_inc >= n_eff) ||
                                                   (rcv_inc >= oc_r + lag_eff))));
  assign last    = (oc_r == n_eff - 1'b1);

  assign wr.we   = accept && is_pix;
  assign wr.addr = gbz_pkg::ADDR_W'(row_r[gbz_pkg::RING_BITS-1:0]) *
                   gbz_pkg::ADDR_W'(gbz_pkg::MAX_WIDTH) + gbz_pkg::ADDR_W'(col_r);
  assign wr.data = in_if.pixel_in;

  assign push     = emit;
  assign push_job = '{row: orow_r, col: ocol_r, last: last};

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    rcv_nxt  = rcv_r;
    oc_nxt   = oc_r;
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (accept && is_pix) begin
      rcv_nxt = rcv_inc;
      if (gbz_pkg::WW'(col_r) == w_eff - 1'b1) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (emit) begin
      oc_nxt = oc_r + 1'b1;
      if (gbz_pkg::WW'(ocol_r) == w_eff - 1'b1) begin
        ocol_nxt = '0;
        orow_nxt = orow_r + 1'b1;
      end else begin
        ocol_nxt = ocol_r + 1'b1;
      end
    end
    // restart on end of frame or geometry change
    if ((emit && last) || geom_wr) begin
      col_nxt  = '0;
      row_nxt  = '0;
      rcv_nxt  = '0;
      oc_nxt   = '0;
      ocol_nxt = '0;
      orow_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_raw_r  <= 11'd512;
      height_raw_r <= 12'd512;
      w0_r         <= 8'd64;
      w1_r         <= 8'd39;
      w2_r         <= 8'd9;
      w3_r         <= 8'd1;
      norm_r       <= 24'd165;
      col_r        <= '0;
      row_r        <= '0;
      rcv_r        <= '0;
      oc_r         <= '0;
      ocol_r       <= '0;
      orow_r       <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      rcv_r  <= rcv_nxt;
      oc_r   <= oc_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
      if (cfg_wr) begin
        case (cfg_if.index)
          gbz_pkg::REG_WIDTH:  width_raw_r  <= cfg_if.data[10:0];
          gbz_pkg::REG_HEIGHT: height_raw_r <= cfg_if.data[11:0];
          gbz_pkg::REG_W0:     w0_r         <= cfg_if.data[7:0];
          gbz_pkg::REG_W1:     w1_r         <= cfg_if.data[7:0];
          gbz_pkg::REG_W2:     w2_r         <= cfg_if.data[7:0];
          gbz_pkg::REG_W3:     w3_r         <= cfg_if.data[7:0];
          gbz_pkg::REG_NORM:   norm_r       <= cfg_if.data[23:0];
          default: ;
        endcase
      end
    end
  end

endmodule

[sv/gbz_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbz_back
// Walks the 49 window taps of one job through the line store, accumulates,
// scales by the reciprocal and holds the result for the output channel.
// ----------------------------------------------------------------------------
module gbz_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gbz_pkg::cfg_t               cfg,
  input  logic                        q_empty,
  input  gbz_pkg::job_t               q_head,
  output logic                        pop,
  output logic                        idle,
  output logic [gbz_pkg::ADDR_W-1:0]  raddr,
  input  logic [7:0]                  rdata,
  gbz_out_if.source                   out_if
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] ty_r, tx_r;
  gbz_pkg::job_t job_r;

  logic                          s1_en_r, s1_tap_r, s2_en_r;
  logic [15:0]                   s1_wp_r;
  logic [23:0]                   s2_p_r;
  logic [gbz_pkg::ACC_W-1:0]     acc_r;
  logic [gbz_pkg::PROD_W-1:0]    prod_r;
  logic [7:0]                    pix_r;
  logic                          last_r, out_valid_r;

  logic signed [gbz_pkg::HW+1:0] rr;
  logic signed [gbz_pkg::CW+2:0] cc;
  logic                          tap_ok, run, end_taps, take;

  function automatic logic [15:0] weight_mult(input gbz_pkg::cfg_t c,
                                              input logic [2:0] y, input logic [2:0] x);
    return 16'(gbz_pkg::weight_sel(c, y)) * 16'(gbz_pkg::weight_sel(c, x));
  endfunction

  assign idle = (state_r == ST_IDLE);
  assign pop  = idle && !q_empty;
  assign run  = (state_r == ST_RUN);
  assign end_taps = (ty_r == 3'd6) && (tx_r == 3'd6);
  assign take = out_if.valid && out_if.ready;

  always_comb begin
    rr = $signed({2'b00, job_r.row}) + $signed((gbz_pkg::HW+2)'(ty_r))
         - (gbz_pkg::HW+2)'(gbz_pkg::KHALF);
    cc = $signed({3'b000, job_r.col}) + $signed((gbz_pkg::CW+3)'(tx_r))
         - (gbz_pkg::CW+3)'(gbz_pkg::KHALF);
    tap_ok = (rr >= 0) && (rr < $signed({2'b00, cfg.height})) &&
             (cc >= 0) && (cc < $signed((gbz_pkg::CW+3)'(cfg.width)));
    raddr = gbz_pkg::ADDR_W'(rr[gbz_pkg::RING_BITS-1:0]) *
            gbz_pkg::ADDR_W'(gbz_pkg::MAX_WIDTH) + gbz_pkg::ADDR_W'(cc[gbz_pkg::CW-1:0]);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (!q_empty) state_nxt = ST_RUN;
      ST_RUN:   if (end_taps) state_nxt = ST_FLUSH;
      ST_FLUSH: if (!s1_en_r && !s2_en_r) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ty_r        <= 3'd0;
      tx_r        <= 3'd0;
      s1_en_r     <= 1'b0;
      s2_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_en_r <= run;
      s2_en_r <= s1_en_r;
      if (run) begin
        if (tx_r == 3'd6) begin
          tx_r <= 3'd0;
          ty_r <= end_taps ? 3'd0 : ty_r + 3'd1;
        end else begin
          tx_r <= tx_r + 3'd1;
        end
      end
      if (state_r == ST_OUT && !out_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // tap pipeline: address and weight, then pixel product, then accumulate
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_head;
      acc_r <= '0;
    end else if (s2_en_r) begin
      acc_r <= acc_r + gbz_pkg::ACC_W'(s2_p_r);
    end
    s1_tap_r <= tap_ok;
    s1_wp_r  <= weight_mult(cfg, ty_r, tx_r);
    s2_p_r   <= s1_tap_r ? 24'(s1_wp_r) * 24'(rdata) : 24'd0;
    if (state_r == ST_MUL) begin
      prod_r <= gbz_pkg::PROD_W'(acc_r) * gbz_pkg::PROD_W'(cfg.norm);
    end
    if (state_r == ST_OUT && !out_valid_r) begin
      pix_r  <= (|prod_r[gbz_pkg::PROD_W-1:40]) ? 8'hFF : prod_r[39:32];
      last_r <= job_r.last;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.pixel_out     = pix_r;
  assign out_if.last_of_frame = last_r;

  a_idle_taps_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (ty_r == 3'd0 && tx_r == 3'd0))
    else $error("tap counters not at origin while idle");

  a_mul_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (!s1_en_r && !s2_en_r))
    else $error("scaling started before the tap pipeline drained");

  a_run_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == ST_RUN && ty_r == 3'd0 && tx_r == 3'd0))
    else $error("job popped without starting the tap walk");

endmodule
